// File: rtl/core/u8sd_pkg.sv
`default_nettype none

package u8sd_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_string;
    } t_in;

    typedef struct packed {
        logic [20:0] code_point;
        logic [2:0]  byte_count;
        logic        last_of_string;
    } t_out;

    localparam logic [20:0] REPL_CP    = 21'h00FFFD;
    localparam int          MAX_RES    = 3;
    localparam int          FIFO_DEPTH = 4;
    localparam int          FIFO_AW    = $clog2(FIFO_DEPTH);

    // Sequence length from the lead byte, 0 when it cannot lead.
    function automatic logic [2:0] lead_len(input logic [7:0] b);
        logic [2:0] len;
        len = 3'd0;
        if (b[7] == 1'b0) begin
            len = 3'd1;
        end else if ((b & 8'hE0) == 8'hC0) begin
            len = 3'd2;
        end else if ((b & 8'hF0) == 8'hE0) begin
            len = 3'd3;
        end else if ((b & 8'hF8) == 8'hF0) begin
            len = 3'd4;
        end
        return len;
    endfunction

    // A lone byte: ASCII passes, anything else is a replacement.
    function automatic logic [20:0] cp_one(input logic [7:0] b);
        return (b[7] == 1'b0) ? {13'd0, b} : REPL_CP;
    endfunction

    function automatic logic [20:0] cp_two(input logic [7:0] b0, input logic [7:0] b1);
        return {10'd0, b0[4:0], b1[5:0]};
    endfunction

    function automatic t_out mk_res(input logic [20:0] cp, input logic [2:0] cnt,
                                    input logic last);
        t_out r;
        r.code_point     = cp;
        r.byte_count     = cnt;
        r.last_of_string = last;
        return r;
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/utf8_stream_decoder.sv
// An accepted byte is registered in the input stage, then decoded into the
// 4-entry result FIFO driving o_out_*. Throughput: one byte per cycle while
// the FIFO holds <= 1 entry; a truncated sequence at string end emits up to
// 3 results from one byte, drained one per cycle while i_out_ready is high.
// Reset (i_rst_n low, synchronous) empties the input stage, the FIFO and
// the pending-sequence counters; buffered byte contents are not cleared.
`default_nettype none

module utf8_stream_decoder (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_in_valid,
    output logic             o_in_ready,
    input  u8sd_pkg::t_in    i_in_data,
    output logic             o_out_valid,
    input  wire              i_out_ready,
    output u8sd_pkg::t_out   o_out_data
);
    import u8sd_pkg::*;

    // ---------------------------------------------------------------
    // Input register stage
    // ---------------------------------------------------------------
    logic r_in_v;
    t_in  r_in;

    // ---------------------------------------------------------------
    // Pending sequence: lead plus up to two continuations
    // ---------------------------------------------------------------
    logic [7:0] r_pend [0:2];
    logic [1:0] r_pc;         // bytes buffered
    logic [1:0] r_nc;         // continuations still missing

    // ---------------------------------------------------------------
    // Result FIFO
    // ---------------------------------------------------------------
    t_out               r_fifo [0:FIFO_DEPTH-1];
    logic [FIFO_AW-1:0] r_head;
    logic [FIFO_AW:0]   r_count;

    // Decode outputs
    t_out       res [0:MAX_RES-1];
    logic [1:0] nres;
    logic [1:0] n_pc;
    logic [1:0] n_nc;
    logic       pend_wr;
    logic [1:0] pend_idx;

    logic       adv;
    logic       pop;
    logic [FIFO_AW-1:0] wr_base;

    logic [7:0]  b;
    logic [2:0]  len_b;
    logic [2:0]  len0;
    logic [2:0]  len1;
    logic [20:0] full_cp;
    logic [2:0]  have;

    // Stage advances only when the FIFO has room for a worst-case burst.
    assign adv        = r_in_v && (r_count <= (FIFO_AW+1)'(FIFO_DEPTH - MAX_RES));
    assign o_in_ready = !r_in_v || adv;
    assign pop        = (r_count != '0) && i_out_ready;
    assign wr_base    = r_head + r_count[FIFO_AW-1:0];

    assign o_out_valid = (r_count != '0);
    assign o_out_data  = r_fifo[r_head];

    always_comb begin
        b     = r_in.data_byte;
        len_b = lead_len(b);
        len0  = lead_len(r_pend[0]);
        len1  = lead_len(r_pend[1]);
        have  = {1'b0, r_pc} + 3'd1;   // bytes in hand including this one

        // Full decode: continuation bytes masked, never checked.
        case (len0)
            3'd2:    full_cp = {10'd0, r_pend[0][4:0], b[5:0]};
            3'd3:    full_cp = {5'd0, r_pend[0][3:0], r_pend[1][5:0], b[5:0]};
            3'd4:    full_cp = {r_pend[0][2:0], r_pend[1][5:0], r_pend[2][5:0], b[5:0]};
            default: full_cp = REPL_CP;
        endcase

        for (int k = 0; k < MAX_RES; k++) begin
            res[k] = mk_res(REPL_CP, 3'd1, 1'b0);
        end
        nres     = 2'd0;
        n_pc     = r_pc;
        n_nc     = r_nc;
        pend_wr  = 1'b0;
        pend_idx = r_pc;

        if (r_in.end_of_string) begin
            // String end always flushes the pending sequence.
            n_pc = 2'd0;
            n_nc = 2'd0;
            if (r_pc == 2'd0) begin
                res[0] = mk_res(cp_one(b), 3'd1, 1'b1);
                nres   = 2'd1;
            end else if (have == len0) begin
                res[0] = mk_res(full_cp, len0, 1'b1);
                nres   = 2'd1;
            end else begin
                // Truncated: lead is replaced, the rest is decoded afresh.
                res[0] = mk_res(REPL_CP, 3'd1, 1'b0);
                if (r_pc == 2'd1) begin
                    res[1] = mk_res(cp_one(b), 3'd1, 1'b1);
                    nres   = 2'd2;
                end else if (len1 == 3'd2) begin
                    res[1] = mk_res(cp_two(r_pend[1], b), 3'd2, 1'b1);
                    nres   = 2'd2;
                end else begin
                    res[1] = mk_res(cp_one(r_pend[1]), 3'd1, 1'b0);
                    res[2] = mk_res(cp_one(b), 3'd1, 1'b1);
                    nres   = 2'd3;
                end
            end
        end else if (r_pc == 2'd0) begin
            if (len_b <= 3'd1) begin
                res[0] = mk_res(cp_one(b), 3'd1, 1'b0);
                nres   = 2'd1;
            end else begin
                pend_wr  = 1'b1;
                pend_idx = 2'd0;
                n_pc     = 2'd1;
                n_nc     = 2'(len_b - 3'd1);
            end
        end else if (r_nc > 2'd1 && r_pc < 2'd3) begin
            pend_wr = 1'b1;
            n_pc    = r_pc + 2'd1;
            n_nc    = r_nc - 2'd1;
        end else begin
            res[0] = mk_res(full_cp, len0, 1'b0);
            nres   = 2'd1;
            n_pc   = 2'd0;
            n_nc   = 2'd0;
        end
    end

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v  <= 1'b0;
            r_pc    <= 2'd0;
            r_nc    <= 2'd0;
            r_head  <= '0;
            r_count <= '0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                r_in_v <= 1'b1;
            end else if (adv) begin
                r_in_v <= 1'b0;
            end
            if (adv) begin
                r_pc <= n_pc;
                r_nc <= n_nc;
            end
            if (pop) begin
                r_head <= r_head + FIFO_AW'(1);
            end
            r_count <= r_count + (adv ? (FIFO_AW+1)'(nres) : '0)
                               - (pop ? (FIFO_AW+1)'(1) : '0);
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in <= i_in_data;
        end
        if (adv && pend_wr) begin
            r_pend[pend_idx] <= b;
        end
        if (adv) begin
            for (int k = 0; k < MAX_RES; k++) begin
                if (2'(k) < nres) begin
                    r_fifo[wr_base + FIFO_AW'(k)] <= res[k];
                end
            end
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/u8sd_checker.sv
`default_nettype none

module u8sd_checker (
    input wire            i_clk,
    input wire            i_rst_n,
    input wire            i_out_valid,
    input wire            i_out_ready,
    input u8sd_pkg::t_out i_out_data
);
    import u8sd_pkg::*;

    a_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result valid dropped before transfer");

    a_data_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_out_data))
        else $error("stalled result changed");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_out_data.byte_count != 3'd0) && (i_out_data.byte_count <= 3'd4))
        else $error("byte_count out of range");

    a_one_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_out_data.byte_count == 3'd1) |->
            (i_out_data.code_point <= 21'h7F) || (i_out_data.code_point == REPL_CP))
        else $error("one-byte result neither ASCII nor replacement");

endmodule

bind utf8_stream_decoder u8sd_checker u_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .i_out_data  (o_out_data)
);

`default_nettype wire
